// ===== rtl/core/wva_pkg.sv =====
// shared constants, codes and struct types for the wavetable voice
// no dependencies; used by the interfaces, the arithmetic units and the top level
package wva_pkg;

  // waveform table
  localparam int TABLE_SIZE = 128;
  localparam int TABLE_AW   = $clog2(TABLE_SIZE);
  localparam int FRAC_W     = 16;
  localparam int PHASE_W    = TABLE_AW + FRAC_W;

  // transaction field widths
  localparam int CMD_W   = 2;
  localparam int STEP_W  = 23;
  localparam int VEL_W   = 16;
  localparam int ADDR_W  = 7;
  localparam int DATA_W  = 16;
  localparam int SMP_W   = 16;

  // configuration
  localparam int LEN_W      = 24;
  localparam int LVL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // envelope and level, 1.0 is 2^16
  localparam int ENV_W = 17;
  localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(65536);

  // level = 1 + (3*vel + 10) / 20
  localparam int VEL3_W = VEL_W + 2;
  localparam logic [VEL3_W-1:0] GAIN_RND = VEL3_W'(10);

  // shared multiplier
  localparam int MUL_AW = 35;
  localparam int MUL_BW = 25;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // x / 20 as (x >> 2) * 52429 >> 18, exact for any 18-bit x
  localparam logic [MUL_BW-1:0] GAIN_RECIP = MUL_BW'(52429);
  localparam int                GAIN_SHIFT = 18;

  // shared divider: quotient known to fit DIV_QW bits
  localparam int DIV_DW = LEN_W;
  localparam int DIV_QW = 17;
  localparam int DIV_NW = DIV_DW + DIV_QW;
  localparam int DIV_CW = $clog2(DIV_QW + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 2'd0,
    CMD_NOTE_ON     = 2'd1,
    CMD_NOTE_OFF    = 2'd2,
    CMD_TABLE_WRITE = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_LEN    = 2'd0,
    CFG_DECAY_LEN     = 2'd1,
    CFG_SUSTAIN_LEVEL = 2'd2,
    CFG_RELEASE_LEN   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                     en;
    logic signed [MUL_AW-1:0] a;
    logic signed [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [DIV_QW-1:0] quotient;
  } div_stat_t;

  // a stage length of zero counts as one
  function automatic logic [LEN_W-1:0] len_or_one(input logic [LEN_W-1:0] v);
    len_or_one = (v == '0) ? LEN_W'(1) : v;
  endfunction

endpackage

// ===== rtl/core/wva_if.sv =====
// valid/ready channel interfaces for the wavetable voice: command, result, config write
// depends on wva_pkg for field widths
interface wva_in_if;
  logic                              valid;
  logic                              ready;
  logic [wva_pkg::CMD_W-1:0]         command;
  logic [wva_pkg::STEP_W-1:0]        phase_step;
  logic [wva_pkg::VEL_W-1:0]         velocity;
  logic [wva_pkg::ADDR_W-1:0]        table_addr;
  logic signed [wva_pkg::DATA_W-1:0] table_data;

  modport source (output valid, command, phase_step, velocity, table_addr, table_data,
                  input ready);
  modport sink (input valid, command, phase_step, velocity, table_addr, table_data,
                output ready);
endinterface

interface wva_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [wva_pkg::SMP_W-1:0] sample;
  logic                             voice_active;

  modport source (output valid, sample, voice_active, input ready);
  modport sink (input valid, sample, voice_active, output ready);
endinterface

interface wva_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wva_pkg::CFG_IDX_W-1:0]  index;
  logic [wva_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/wva_mul.sv =====
// shared signed multiplier with registered product
// depends on wva_pkg for mul_req_t and widths
module wva_mul (
  input  logic                              clk_i,
  input  wva_pkg::mul_req_t                 req_i,
  output logic signed [wva_pkg::MUL_PW-1:0] p_o
);

  logic signed [wva_pkg::MUL_PW-1:0] a_ext;
  logic signed [wva_pkg::MUL_PW-1:0] b_ext;
  logic signed [wva_pkg::MUL_PW-1:0] p_q;

  assign a_ext = wva_pkg::MUL_PW'(req_i.a);
  assign b_ext = wva_pkg::MUL_PW'(req_i.b);

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      p_q <= a_ext * b_ext;
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/wva_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on wva_pkg; the caller guarantees the quotient fits DIV_QW bits
module wva_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wva_pkg::div_req_t  req_i,
  output wva_pkg::div_stat_t stat_o
);

  logic                        busy_q, busy_d;
  logic [wva_pkg::DIV_CW-1:0]  cnt_q, cnt_d;
  logic [wva_pkg::DIV_DW-1:0]  rem_q, rem_d;
  logic [wva_pkg::DIV_QW-1:0]  dvd_q, dvd_d;
  logic [wva_pkg::DIV_QW-1:0]  quo_q, quo_d;
  logic [wva_pkg::DIV_DW-1:0]  dsr_q, dsr_d;
  logic [wva_pkg::DIV_DW+1:0]  trial;
  logic                        neg;

  assign trial = {1'b0, rem_q, dvd_q[wva_pkg::DIV_QW-1]} - {2'b00, dsr_q};
  assign neg   = trial[wva_pkg::DIV_DW+1];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      // upper dividend bits are already below the divisor
      busy_d = 1'b1;
      cnt_d  = wva_pkg::DIV_CW'(wva_pkg::DIV_QW);
      rem_d  = req_i.dividend[wva_pkg::DIV_NW-1:wva_pkg::DIV_QW];
      dvd_d  = req_i.dividend[wva_pkg::DIV_QW-1:0];
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = neg ? {rem_q[wva_pkg::DIV_DW-2:0], dvd_q[wva_pkg::DIV_QW-1]}
                  : trial[wva_pkg::DIV_DW-1:0];
      dvd_d = {dvd_q[wva_pkg::DIV_QW-2:0], 1'b0};
      quo_d = {quo_q[wva_pkg::DIV_QW-2:0], ~neg};
      cnt_d = cnt_q - wva_pkg::DIV_CW'(1);
      if (cnt_q == wva_pkg::DIV_CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy     = busy_q;
  assign stat_o.quotient = quo_q;

endmodule

// ===== rtl/core/wavetable_voice_with_adsr.sv =====
// wavetable voice with linear interpolation and linear ADSR envelope, top level
// depends on wva_pkg, wva_if.sv (channels), wva_mul and wva_div
//
//   channel  | dir | handshake     | payload
//   in_i     | in  | valid/ready   | command, phase_step, velocity, table_addr, table_data
//   cfg_i    | in  | valid/ready   | index, data (ready always high)
//   out_o    | out | valid/ready   | sample, voice_active
//
// a sounding tick makes four passes through the shared multiplier and waits on the
// shared divider for the envelope ramp; a silent tick goes straight to the output state
// a note_on computes the level by reciprocal multiply on the shared multiplier;
// note_off and table_write are handled in the accepting state itself
// reset clears voice state and config to defaults; the waveform table is not cleared
// a result waits in the output register while the next transaction is accepted;
// a tick finishing while that register is still full holds until the result drains

module wavetable_voice_with_adsr (
  input logic       clk_i,
  input logic       rst_ni,
  wva_in_if.sink    in_i,
  wva_cfg_if.sink   cfg_i,
  wva_out_if.source out_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_GAIN = 9'b000000010,
    S_EMUL = 9'b000000100,
    S_IMUL = 9'b000001000,
    S_GMUL = 9'b000010000,
    S_WDIV = 9'b000100000,
    S_VMUL = 9'b001000000,
    S_SAT  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_e;

  typedef enum logic [4:0] {
    ENV_IDLE    = 5'b00001,
    ENV_ATTACK  = 5'b00010,
    ENV_DECAY   = 5'b00100,
    ENV_SUSTAIN = 5'b01000,
    ENV_RELEASE = 5'b10000
  } env_stage_e;

  localparam logic signed [27:0] SMP_MAX = 28'sd32767;
  localparam logic signed [27:0] SMP_MIN = -28'sd32768;

  // configuration
  logic [wva_pkg::LEN_W-1:0] attack_q, decay_q, release_q;
  logic [wva_pkg::LVL_W-1:0] sus_q;

  // voice state
  state_e                      state_q, state_d;
  env_stage_e                  stage_q, stage_d;
  logic [wva_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [wva_pkg::STEP_W-1:0]  step_q, step_d;
  logic [wva_pkg::ENV_W-1:0]   gain_q, gain_d;
  logic [wva_pkg::LEN_W-1:0]   cnt_q, cnt_d;

  // work and output registers
  logic signed [wva_pkg::DATA_W-1:0] v0_q, v0_d;
  logic [wva_pkg::ENV_W-1:0]         env_q, env_d;
  logic signed [wva_pkg::SMP_W-1:0]  sample_q, sample_d;
  logic                              active_q, active_d;
  logic                              out_valid_q, out_valid_d;
  logic signed [wva_pkg::SMP_W-1:0]  out_sample_q, out_sample_d;
  logic                              out_active_q, out_active_d;

  // waveform table
  logic signed [wva_pkg::DATA_W-1:0]  wave_mem [wva_pkg::TABLE_SIZE];
  logic signed [wva_pkg::DATA_W-1:0]  rd_q;
  logic                               mem_we, mem_re;
  logic [wva_pkg::TABLE_AW-1:0]       mem_waddr, mem_raddr;

  // shared units
  wva_pkg::mul_req_t                 mul_req;
  logic signed [wva_pkg::MUL_PW-1:0] mul_p;
  wva_pkg::div_req_t                 div_req;
  wva_pkg::div_stat_t                div_stat;

  logic                          in_fire, cfg_fire;
  wva_pkg::cmd_e                 cmd;
  logic [wva_pkg::TABLE_AW-1:0]  idx0, idx1;
  logic [wva_pkg::LEN_W-1:0]     len_cur, n_cur;
  logic [wva_pkg::ENV_W-1:0]     amt_cur, base_cur;
  logic [wva_pkg::VEL3_W-1:0]    vel3;
  logic signed [16:0]            diff;
  logic [16:0]                   interp;
  logic signed [27:0]            smp;
  logic [wva_pkg::LEN_W:0]       cnt_inc;
  logic                          stage_end;

  wva_mul u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .p_o   (mul_p)
  );

  wva_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat)
  );

  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign cmd      = wva_pkg::cmd_e'(in_i.command);

  assign in_i.ready   = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.sample       = out_sample_q;
  assign out_o.voice_active = out_active_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= wva_pkg::LEN_W'(1);
      decay_q   <= wva_pkg::LEN_W'(1);
      sus_q     <= '0;
      release_q <= wva_pkg::LEN_W'(1);
    end else if (cfg_fire) begin
      case (wva_pkg::cfg_idx_e'(cfg_i.index))
        wva_pkg::CFG_ATTACK_LEN:    attack_q  <= cfg_i.data;
        wva_pkg::CFG_DECAY_LEN:     decay_q   <= cfg_i.data;
        wva_pkg::CFG_SUSTAIN_LEVEL: sus_q     <= cfg_i.data[wva_pkg::LVL_W-1:0];
        wva_pkg::CFG_RELEASE_LEN:   release_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wave_mem[mem_waddr] <= in_i.table_data;
    end
    if (mem_re) begin
      rd_q <= wave_mem[mem_raddr];
    end
  end

  // envelope ramp parameters of the current stage; sustain ramps by zero
  always_comb begin
    case (stage_q)
      ENV_ATTACK: begin
        len_cur  = wva_pkg::len_or_one(attack_q);
        amt_cur  = wva_pkg::ENV_ONE;
        base_cur = wva_pkg::ENV_ONE;
      end
      ENV_DECAY: begin
        len_cur  = wva_pkg::len_or_one(decay_q);
        amt_cur  = wva_pkg::ENV_ONE - {1'b0, sus_q};
        base_cur = wva_pkg::ENV_ONE;
      end
      ENV_RELEASE: begin
        len_cur  = wva_pkg::len_or_one(release_q);
        amt_cur  = {1'b0, sus_q};
        base_cur = {1'b0, sus_q};
      end
      default: begin
        len_cur  = wva_pkg::LEN_W'(1);
        amt_cur  = '0;
        base_cur = {1'b0, sus_q};
      end
    endcase
  end

  assign n_cur     = (cnt_q < len_cur) ? cnt_q : len_cur;
  assign cnt_inc   = {1'b0, cnt_q} + (wva_pkg::LEN_W + 1)'(1);
  assign stage_end = (cnt_inc >= {1'b0, len_cur});

  assign idx0 = phase_q[wva_pkg::PHASE_W-1:wva_pkg::FRAC_W];
  assign idx1 = (idx0 == wva_pkg::TABLE_AW'(wva_pkg::TABLE_SIZE - 1))
              ? '0 : idx0 + wva_pkg::TABLE_AW'(1);

  assign vel3   = {2'b00, in_i.velocity} + {1'b0, in_i.velocity, 1'b0} + wva_pkg::GAIN_RND;
  assign diff   = {rd_q[15], rd_q} - {v0_q[15], v0_q};
  // floor of the interpolation product over 2^16 is an arithmetic shift
  assign interp = {v0_q[15], v0_q} + mul_p[32:16];
  assign smp    = mul_p[wva_pkg::MUL_PW-1:32];

  always_comb begin
    state_d      = state_q;
    stage_d      = stage_q;
    phase_d      = phase_q;
    step_d       = step_q;
    gain_d       = gain_q;
    cnt_d        = cnt_q;
    v0_d         = v0_q;
    env_d        = env_q;
    sample_d     = sample_q;
    active_d     = active_q;
    out_sample_d = out_sample_q;
    out_active_d = out_active_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    mem_we       = 1'b0;
    mem_waddr    = wva_pkg::TABLE_AW'(in_i.table_addr);
    mem_re       = 1'b0;
    mem_raddr    = idx0;
    mul_req      = '0;
    div_req      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd)
            wva_pkg::CMD_TICK: begin
              if (stage_q == ENV_IDLE || step_q == '0) begin
                sample_d = '0;
                active_d = (stage_q != ENV_IDLE);
                state_d  = S_EMIT;
              end else begin
                mem_re   = 1'b1;
                active_d = 1'b1;
                state_d  = S_EMUL;
              end
            end
            wva_pkg::CMD_NOTE_ON: begin
              step_d     = in_i.phase_step;
              phase_d    = '0;
              stage_d    = ENV_ATTACK;
              cnt_d      = wva_pkg::LEN_W'(1);
              mul_req.en = 1'b1;
              mul_req.a  = wva_pkg::MUL_AW'(vel3[wva_pkg::VEL3_W-1:2]);
              mul_req.b  = wva_pkg::GAIN_RECIP;
              state_d    = S_GAIN;
            end
            wva_pkg::CMD_NOTE_OFF: begin
              if (stage_q == ENV_ATTACK || stage_q == ENV_DECAY || stage_q == ENV_SUSTAIN) begin
                stage_d = ENV_RELEASE;
                cnt_d   = wva_pkg::LEN_W'(1);
              end
            end
            wva_pkg::CMD_TABLE_WRITE: begin
              mem_we = (32'(in_i.table_addr) < wva_pkg::TABLE_SIZE);
            end
            default: ;
          endcase
        end
      end
      S_GAIN: begin
        gain_d  = wva_pkg::ENV_ONE
                + {1'b0, mul_p[wva_pkg::GAIN_SHIFT+wva_pkg::VEL_W-1:wva_pkg::GAIN_SHIFT]};
        state_d = S_IDLE;
      end
      S_EMUL: begin
        // ramp amount times clamped count; second table read
        mul_req.en = 1'b1;
        mul_req.a  = {18'd0, amt_cur};
        mul_req.b  = {1'b0, n_cur};
        mem_re     = 1'b1;
        mem_raddr  = idx1;
        v0_d       = rd_q;
        state_d    = S_IMUL;
      end
      S_IMUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_p[wva_pkg::DIV_NW-1:0];
        div_req.divisor  = len_cur;
        mul_req.en = 1'b1;
        mul_req.a  = {19'd0, phase_q[wva_pkg::FRAC_W-1:0]};
        mul_req.b  = {{8{diff[16]}}, diff};
        state_d    = S_GMUL;
      end
      S_GMUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{19{interp[15]}}, interp[15:0]};
        mul_req.b  = {8'd0, gain_q};
        state_d    = S_WDIV;
      end
      S_WDIV: begin
        if (!div_stat.busy) begin
          env_d   = (stage_q == ENV_ATTACK) ? div_stat.quotient
                                            : base_cur - div_stat.quotient;
          state_d = S_VMUL;
        end
      end
      S_VMUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = mul_p[wva_pkg::MUL_AW-1:0];
        mul_req.b  = {8'd0, env_q};
        state_d    = S_SAT;
      end
      S_SAT: begin
        if (smp > SMP_MAX) begin
          sample_d = SMP_MAX[15:0];
        end else if (smp < SMP_MIN) begin
          sample_d = SMP_MIN[15:0];
        end else begin
          sample_d = smp[15:0];
        end
        phase_d = phase_q + wva_pkg::PHASE_W'(step_q);
        case (stage_q)
          ENV_ATTACK: begin
            if (stage_end) begin
              stage_d = ENV_DECAY;
              cnt_d   = wva_pkg::LEN_W'(1);
            end else begin
              cnt_d = cnt_inc[wva_pkg::LEN_W-1:0];
            end
          end
          ENV_DECAY: begin
            if (stage_end) begin
              stage_d = ENV_SUSTAIN;
              cnt_d   = wva_pkg::LEN_W'(1);
            end else begin
              cnt_d = cnt_inc[wva_pkg::LEN_W-1:0];
            end
          end
          ENV_RELEASE: begin
            if (stage_end) begin
              stage_d = ENV_IDLE;
              step_d  = '0;
              cnt_d   = wva_pkg::LEN_W'(1);
            end else begin
              cnt_d = cnt_inc[wva_pkg::LEN_W-1:0];
            end
          end
          default: ;
        endcase
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_sample_d = sample_q;
          out_active_d = active_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stage_q     <= ENV_IDLE;
      phase_q     <= '0;
      step_q      <= '0;
      gain_q      <= wva_pkg::ENV_ONE;
      cnt_q       <= wva_pkg::LEN_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      gain_q      <= gain_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v0_q         <= v0_d;
    env_q        <= env_d;
    sample_q     <= sample_d;
    active_q     <= active_d;
    out_sample_q <= out_sample_d;
    out_active_q <= out_active_d;
  end

endmodule

// ===== dv/wva_voice_checker.sv =====
// scoreboard for the wavetable voice: watches the command, config and sample channels,
// predicts each tick's sample and compares it; depends on wva_pkg and wva_if.sv
module wva_voice_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  wva_in_if           in_i,
  wva_cfg_if          cfg_i,
  wva_out_if          out_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);
  import wva_pkg::*;

  typedef enum logic [2:0] {
    ENV_IDLE,
    ENV_ATTACK,
    ENV_DECAY,
    ENV_SUSTAIN,
    ENV_RELEASE
  } env_stage_e;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    active;
  } voice_out_t;

  logic [LEN_W-1:0]         attack_len, decay_len, release_len;
  logic [LVL_W-1:0]         sustain_lvl;
  logic signed [DATA_W-1:0] wave_mem [TABLE_SIZE];
  logic [PHASE_W-1:0]       phase;
  logic [STEP_W-1:0]        step;
  logic [ENV_W-1:0]         gain;
  env_stage_e               stage;
  longint                   stage_cnt;
  voice_out_t               sample_q[$];

  // linear ramp share of amount, counter clamped to the stage length
  function automatic longint ramp(input longint amount, input longint len);
    longint n;
    n = (stage_cnt < len) ? stage_cnt : len;
    return (amount * n) / len;
  endfunction

  function automatic voice_out_t voice_tick();
    voice_out_t          res;
    longint              len, env, sus, v0, v1, frac, interp, g, prod, smp;
    logic [TABLE_AW-1:0] idx0, idx1;
    res.sample = '0;
    res.active = (stage != ENV_IDLE);
    if (stage == ENV_IDLE || step == '0) return res;
    len = 1;
    sus = sustain_lvl;
    case (stage)
      ENV_ATTACK: begin
        len = (attack_len == '0) ? 1 : attack_len;
        env = ramp(65536, len);
      end
      ENV_DECAY: begin
        len = (decay_len == '0) ? 1 : decay_len;
        env = 65536 - ramp(65536 - sus, len);
      end
      ENV_SUSTAIN: env = sus;
      default: begin
        len = (release_len == '0) ? 1 : release_len;
        env = sus - ramp(sus, len);
      end
    endcase
    idx0   = phase[PHASE_W-1:FRAC_W];
    idx1   = idx0 + 1'b1;
    frac   = phase[FRAC_W-1:0];
    v0     = wave_mem[idx0];
    v1     = wave_mem[idx1];
    interp = v0 + ((frac * (v1 - v0)) >>> FRAC_W);
    g      = gain;
    prod   = interp * g * env;
    smp    = prod >>> 32;
    if (smp > 32767) smp = 32767;
    else if (smp < -32768) smp = -32768;
    res.sample = smp[SMP_W-1:0];
    res.active = 1'b1;
    phase = phase + step;
    if (stage == ENV_ATTACK || stage == ENV_DECAY) begin
      stage_cnt++;
      if (stage_cnt >= len) begin
        stage     = (stage == ENV_ATTACK) ? ENV_DECAY : ENV_SUSTAIN;
        stage_cnt = 1;
      end
    end else if (stage == ENV_RELEASE) begin
      stage_cnt++;
      if (stage_cnt >= len) begin
        stage     = ENV_IDLE;
        step      = '0;
        stage_cnt = 1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    voice_out_t got, want;
    if (!rst_ni) begin
      attack_len  = LEN_W'(1);
      decay_len   = LEN_W'(1);
      release_len = LEN_W'(1);
      sustain_lvl = '0;
      phase       = '0;
      step        = '0;
      gain        = ENV_ONE;
      stage       = ENV_IDLE;
      stage_cnt   = 1;
      sample_q.delete();
      err_cnt_o   = 0;
      pending_o   = 0;
    end else begin
      // results leave before the transaction accepted at the same edge is predicted
      if (out_i.valid && out_i.ready) begin
        got.sample = out_i.sample;
        got.active = out_i.voice_active;
        if (sample_q.size() == 0) begin
          err_cnt_o++;
          $display("%0t: unexpected sample: expected none, actual %0d active %0b",
                   $time, got.sample, got.active);
        end else begin
          want = sample_q.pop_front();
          if (got.sample !== want.sample) begin
            err_cnt_o++;
            $display("%0t: sample mismatch: expected %0d, actual %0d",
                     $time, want.sample, got.sample);
          end
          if (got.active !== want.active) begin
            err_cnt_o++;
            $display("%0t: voice_active mismatch: expected %0b, actual %0b",
                     $time, want.active, got.active);
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_ATTACK_LEN:    attack_len  = cfg_i.data[LEN_W-1:0];
          CFG_DECAY_LEN:     decay_len   = cfg_i.data[LEN_W-1:0];
          CFG_SUSTAIN_LEVEL: sustain_lvl = cfg_i.data[LVL_W-1:0];
          CFG_RELEASE_LEN:   release_len = cfg_i.data[LEN_W-1:0];
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        case (cmd_e'(in_i.command))
          CMD_TICK: sample_q.push_back(voice_tick());
          CMD_NOTE_ON: begin
            step      = in_i.phase_step;
            gain      = ENV_W'(65536 + (3 * int'(in_i.velocity) + 10) / 20);
            phase     = '0;
            stage     = ENV_ATTACK;
            stage_cnt = 1;
          end
          CMD_NOTE_OFF: begin
            if (stage == ENV_ATTACK || stage == ENV_DECAY || stage == ENV_SUSTAIN) begin
              stage     = ENV_RELEASE;
              stage_cnt = 1;
            end
          end
          CMD_TABLE_WRITE: wave_mem[in_i.table_addr] = in_i.table_data;
        endcase
      end
      pending_o = sample_q.size();
    end
  end

endmodule

// ===== dv/tb_wavetable_voice_with_adsr.sv =====
// testbench top for the wavetable voice: clock, reset, command and config stimulus,
// sample channel backpressure, watchdog and verdict; depends on wva_pkg, wva_if.sv,
// the voice top level and wva_voice_checker
module tb_wavetable_voice_with_adsr;
  import wva_pkg::*;

  localparam int TOTAL_ITEMS    = 600;
  localparam int QUIET_TAIL     = 100;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  int unsigned err_cnt;
  int unsigned pending_cnt;
  int          items_sent;
  bit          calm;
  bit          no_idle;
  bit          hold_req;

  wva_in_if  in_ch();
  wva_cfg_if cfg_ch();
  wva_out_if out_ch();

  wavetable_voice_with_adsr i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  wva_voice_checker i_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_ch),
    .cfg_i     (cfg_ch),
    .out_i     (out_ch),
    .err_cnt_o (err_cnt),
    .pending_o (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sample consumer with random stall bursts and one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && !no_idle && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb_wavetable_voice_with_adsr: errors");
    $finish;
  end

  task automatic send_cmd(input cmd_e cmd, input logic [STEP_W-1:0] step,
                          input logic [VEL_W-1:0] vel, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] data);
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.phase_step <= step;
    in_ch.velocity   <= vel;
    in_ch.table_addr <= addr;
    in_ch.table_data <= data;
    do begin
      @(posedge clk);
    end while (in_ch.ready !== 1'b1);
    items_sent++;
    if (!calm && !no_idle && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
    end
  endtask

  task automatic play_tick();
    send_cmd(CMD_TICK, STEP_W'($urandom), VEL_W'($urandom), ADDR_W'($urandom),
             DATA_W'($urandom));
  endtask

  task automatic key_on(input logic [STEP_W-1:0] step, input logic [VEL_W-1:0] vel);
    send_cmd(CMD_NOTE_ON, step, vel, ADDR_W'($urandom), DATA_W'($urandom));
  endtask

  task automatic key_off();
    send_cmd(CMD_NOTE_OFF, STEP_W'($urandom), VEL_W'($urandom), ADDR_W'($urandom),
             DATA_W'($urandom));
  endtask

  task automatic load_entry(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    send_cmd(CMD_TABLE_WRITE, STEP_W'($urandom), VEL_W'($urandom), addr, data);
  endtask

  // wait for every sample, then let a note_on still in flight finish
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do begin
      @(posedge clk);
    end while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_cfg(input cfg_idx_e idx);
    if (idx == CFG_SUSTAIN_LEVEL) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return CFG_DATA_W'(16'hFFFF);
        default: return CFG_DATA_W'($urandom_range(0, 65535));
      endcase
    end
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {CFG_DATA_W{1'b1}};
      2: return CFG_DATA_W'($urandom_range(100, 5000));
      default: return CFG_DATA_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return STEP_W'($urandom);
      2: return {STEP_W{1'b1}};
      default: return STEP_W'($urandom_range(1, 24'h40000));
    endcase
  endfunction

  initial begin : stimulus
    int       phase_no;
    cfg_idx_e idx;
    rst_n            = 1'b0;
    calm             = 1'b0;
    no_idle          = 1'b0;
    hold_req         = 1'b0;
    items_sent       = 0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_TICK;
    in_ch.phase_step <= '0;
    in_ch.velocity   <= '0;
    in_ch.table_addr <= '0;
    in_ch.table_data <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_ATTACK_LEN;
    cfg_ch.data      <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle voice: silent tick and a stray release
    play_tick();
    key_off();
    play_tick();

    // whole table is written before anything can read it
    for (int i = 0; i < TABLE_SIZE; i++) begin
      case (i)
        0:       load_entry(ADDR_W'(i), 16'h7FFF);
        1, 127:  load_entry(ADDR_W'(i), 16'h8000);
        64:      load_entry(ADDR_W'(i), 16'h0000);
        default: load_entry(ADDR_W'(i), DATA_W'($urandom));
      endcase
    end

    // zero stage lengths count as one
    settle();
    set_reg(CFG_ATTACK_LEN, '0);
    set_reg(CFG_DECAY_LEN, '0);
    set_reg(CFG_SUSTAIN_LEVEL, CFG_DATA_W'(16'hFFFF));
    set_reg(CFG_RELEASE_LEN, '0);
    // zero step: silent but active, also in release
    key_on('0, '0);
    play_tick();
    key_off();
    play_tick();
    // full step and velocity through every stage, saturating, then idle
    key_on({STEP_W{1'b1}}, 16'hFFFF);
    repeat (3) play_tick();
    key_off();
    play_tick();
    play_tick();
    // repeated note_on sets the level anew, note_off while releasing is ignored
    key_on(STEP_W'(24'h10000), 16'h8000);
    play_tick();
    key_on(STEP_W'(24'h8000), '0);
    play_tick();
    key_off();
    key_off();
    play_tick();

    // attack shortened below the running count
    settle();
    set_reg(CFG_ATTACK_LEN, CFG_DATA_W'(50));
    key_on(STEP_W'(24'h3000), VEL_W'($urandom));
    repeat (6) play_tick();
    settle();
    set_reg(CFG_ATTACK_LEN, CFG_DATA_W'(3));
    repeat (2) play_tick();

    phase_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      settle();
      calm    = ($urandom_range(0, 3) == 0);
      no_idle = (items_sent >= TOTAL_ITEMS - QUIET_TAIL);
      repeat ($urandom_range(1, 4)) begin
        idx = cfg_idx_e'($urandom_range(0, 3));
        set_reg(idx, pick_cfg(idx));
      end
      // consumer stalls for a long stretch while ticks keep coming
      if (phase_no == 2) hold_req = 1'b1;
      if (phase_no == 2 || $urandom_range(0, 4) != 0) begin
        key_on(pick_step(), VEL_W'($urandom));
        repeat ($urandom_range(2, 30)) begin
          if ($urandom_range(0, 15) == 0) load_entry(ADDR_W'($urandom), DATA_W'($urandom));
          else play_tick();
        end
        // now and then the note keeps sounding into the next settings
        if ($urandom_range(0, 5) != 0) key_off();
        repeat ($urandom_range(1, 25)) play_tick();
      end else begin
        repeat ($urandom_range(4, 12)) begin
          send_cmd(cmd_e'($urandom_range(0, 3)), STEP_W'($urandom), VEL_W'($urandom),
                   ADDR_W'($urandom), DATA_W'($urandom));
        end
      end
      phase_no++;
    end

    settle();
    if (err_cnt == 0) $display("tb_wavetable_voice_with_adsr: clean");
    else $display("tb_wavetable_voice_with_adsr: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/wva_pkg.sv
rtl/core/wva_if.sv
rtl/core/wva_mul.sv
rtl/core/wva_div.sv
rtl/core/wavetable_voice_with_adsr.sv
dv/wva_voice_checker.sv
dv/tb_wavetable_voice_with_adsr.sv
